### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is high.
`define MBR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mbr: assertion failed");

// Property checked at every rising edge, also during reset.
`define MBR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mbr: assertion failed");

`endif

### rtl/mbr_pkg.sv
// Types and constants of the MSB-first bit reader.
package mbr_pkg;

   // Holding word and window geometry.
   localparam int WORD_BITS    = 32;
   localparam int WINDOW_BYTES = 8;
   localparam int WIN_W        = 64;

   // Port field widths.
   localparam int BITCNT_W  = 6;
   localparam int BYTECNT_W = 4;
   localparam int VALUE_W   = 64;
   localparam int USED_W    = 4;

   // Width of a bit count in the range 0 to WORD_BITS.
   localparam int CNT_W = $clog2(WORD_BITS + 1);

   // Request kinds.
   typedef enum logic [0:0] {
      ACT_BIT_FIELD    = 1'b0,
      ACT_BYTE_ALIGNED = 1'b1
   } action_type;

endpackage

### rtl/msb_first_bit_reader.sv
// MSB-first bit reader: one request per cycle while the result side does not stall.
// One barrel-shift pass sits between the request register and the result
// register, and the holding word updates as an item moves through it.
// Synchronous active-high reset empties both registers and clears the holding
// word and its bit count to zero.
module msb_first_bit_reader (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [mbr_pkg::BITCNT_W-1:0]   req_bit_count,
   input  logic [mbr_pkg::BYTECNT_W-1:0]  req_byte_count,
   input  logic [mbr_pkg::WIN_W-1:0]      req_window,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mbr_pkg::VALUE_W-1:0]    rsp_value,
   output logic [mbr_pkg::USED_W-1:0]     rsp_bytes_used
);
   import mbr_pkg::*;

   // Request register.
   logic                 in_valid_ff, in_valid_in;
   logic                 in_action_ff;
   logic [BITCNT_W-1:0]  in_bit_count_ff;
   logic [BYTECNT_W-1:0] in_byte_count_ff;
   logic [WIN_W-1:0]     in_window_ff;

   // Reader state.
   logic [WORD_BITS-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0]     bits_left_ff, bits_left_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [USED_W-1:0]    rsp_used_ff, rsp_used_in;

   logic                 req_take;
   logic                 advance;

   // Working values of the shift pass.
   logic [CNT_W-1:0]     want;
   logic [CNT_W-1:0]     have;
   logic [CNT_W-1:0]     miss;
   logic [CNT_W-1:0]     fill_bits;
   logic [2:0]           nfill;
   logic [2:0]           rest;
   logic [BYTECNT_W-1:0] nbytes;
   logic [VALUE_W-1:0]   old_bits;
   logic [VALUE_W-1:0]   new_bits;
   logic [WIN_W-1:0]     win_left;

   // Handshake: the pass moves an item on whenever the result register is free
   // or is being drained in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // Read counts: bit counts clamped to the word size, byte count to the window.
   always_comb begin
      want = (in_bit_count_ff > BITCNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS)
                                                      : CNT_W'(in_bit_count_ff);
      have = (bits_left_ff > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : bits_left_ff;
      miss = want - have;
      nfill = 3'((miss + CNT_W'(7)) >> 3);
      fill_bits = CNT_W'({nfill, 3'b000});
      rest = 3'(fill_bits - miss);
      nbytes = (in_byte_count_ff > BYTECNT_W'(WINDOW_BYTES)) ? BYTECNT_W'(WINDOW_BYTES)
                                                             : in_byte_count_ff;
   end

   // Shifters: pending bits right-justified, and the leading window bits.
   always_comb begin
      old_bits = {{(VALUE_W - WORD_BITS){1'b0}}, hold_ff}
                 >> (CNT_W'(WORD_BITS) - have);
      new_bits = VALUE_W'(in_window_ff >> (7'(WIN_W) - 7'(miss)));
      win_left = in_window_ff << miss;
   end

   // Result and next state for the item in the request register.
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_used_in  = rsp_used_ff;
      hold_in      = hold_ff;
      bits_left_in = bits_left_ff;
      if (advance) begin
         case (action_type'(in_action_ff))
            ACT_BYTE_ALIGNED: begin
               rsp_value_in = VALUE_W'(in_window_ff >> (7'(WIN_W) - 7'({nbytes, 3'b000})));
               rsp_used_in  = USED_W'(nbytes);
               hold_in      = '0;
               bits_left_in = '0;
            end
            ACT_BIT_FIELD: begin
               if (have >= want) begin
                  // Enough pending bits: take them from the top of the word.
                  rsp_value_in = {{(VALUE_W - WORD_BITS){1'b0}}, hold_ff}
                                 >> (CNT_W'(WORD_BITS) - want);
                  rsp_used_in  = '0;
                  hold_in      = hold_ff << want;
                  bits_left_in = have - want;
               end else begin
                  // Refill whole bytes and keep the unused bits at the top.
                  rsp_value_in = (old_bits << miss) | new_bits;
                  rsp_used_in  = USED_W'(nfill);
                  hold_in      = win_left[WIN_W-1 -: WORD_BITS]
                                 & ~({WORD_BITS{1'b1}} >> rest);
                  bits_left_in = CNT_W'(rest);
               end
            end
            default: begin
               rsp_value_in = '0;
               rsp_used_in  = '0;
            end
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= '0;
         bits_left_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         bits_left_ff <= bits_left_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff     <= req_action;
         in_bit_count_ff  <= req_bit_count;
         in_byte_count_ff <= req_byte_count;
         in_window_ff     <= req_window;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_used_ff  <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_bytes_used = rsp_used_ff;

endmodule

### rtl/mbr_checker.sv
// Port checker for the MSB-first bit reader, bound into every instance of the reader module.
`include "assert_macros.svh"

module mbr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_action,
   input logic [mbr_pkg::BITCNT_W-1:0]   req_bit_count,
   input logic [mbr_pkg::BYTECNT_W-1:0]  req_byte_count,
   input logic [mbr_pkg::WIN_W-1:0]      req_window,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [mbr_pkg::VALUE_W-1:0]    rsp_value,
   input logic [mbr_pkg::USED_W-1:0]     rsp_bytes_used
);
   import mbr_pkg::*;

   // A stalled result stays offered.
   `MBR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // The result channel is empty right after reset.
   `MBR_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // No more bytes are consumed than the window holds.
   `MBR_ASSERT(a_used_max, clock, reset, rsp_valid |-> rsp_bytes_used <= USED_W'(WINDOW_BYTES))

   // A result that used at most four bytes fits in 32 bits.
   `MBR_ASSERT(a_value_narrow, clock, reset,
      rsp_valid && rsp_bytes_used <= USED_W'(4) |-> rsp_value[VALUE_W-1:32] == '0)

endmodule

bind msb_first_bit_reader mbr_checker u_mbr_checker (.*);

### test/msb_first_bit_reader_checker.sv
// Checker that predicts every bit reader result and compares it with the block's output.
`timescale 1ns / 100ps

module msb_first_bit_reader_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_action,
   input  logic [mbr_pkg::BITCNT_W-1:0]   req_bit_count,
   input  logic [mbr_pkg::BYTECNT_W-1:0]  req_byte_count,
   input  logic [mbr_pkg::WIN_W-1:0]      req_window,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [mbr_pkg::VALUE_W-1:0]    rsp_value,
   input  logic [mbr_pkg::USED_W-1:0]     rsp_bytes_used,
   output int                             failures,
   output int                             outstanding
);
   import mbr_pkg::*;

   // One result as the block should return it.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [USED_W-1:0]  bytes_used;
   } read_result_type;

   // Private copy of the reader state: pending bits, left-aligned, and their count.
   logic [WORD_BITS-1:0] hold_word  = '0;
   logic [5:0]           hold_count = '0;

   read_result_type expected_reads[$];
   int              mismatch_count = 0;

   // Works out the result of one request and advances the private reader state.
   function automatic read_result_type predict_read(input action_type act,
                                                    input logic [BITCNT_W-1:0] bit_cnt,
                                                    input logic [BYTECNT_W-1:0] byte_cnt,
                                                    input logic [WIN_W-1:0] window);
      int unsigned     want;
      int unsigned     have;
      int unsigned     miss;
      int unsigned     nbytes;
      int unsigned     spare;
      logic [63:0]     fresh;
      logic [63:0]     old_bits;
      logic [63:0]     new_bits;
      logic [63:0]     refill;
      read_result_type res;

      res = '0;
      if (act == ACT_BYTE_ALIGNED) begin
         // Aligned read: leading bytes of the window; pending bits are dropped.
         nbytes = (byte_cnt > WINDOW_BYTES) ? WINDOW_BYTES : byte_cnt;
         res.value = (nbytes == 0) ? '0 : (window >> (64 - 8 * nbytes));
         res.bytes_used = USED_W'(nbytes);
         hold_word = '0;
         hold_count = '0;
      end else begin
         want = (bit_cnt > WORD_BITS) ? WORD_BITS : bit_cnt;
         have = (hold_count > WORD_BITS) ? WORD_BITS : hold_count;
         if (have >= want) begin
            // Enough pending bits: take them from the top of the holding word.
            if (want != 0) begin
               old_bits = {32'b0, hold_word};
               res.value = old_bits >> (WORD_BITS - want);
               hold_word = hold_word << want;
               hold_count = 6'(have - want);
            end
         end else begin
            // Too few pending bits: load only the whole bytes that cover the shortfall.
            miss = want - have;
            nbytes = (miss + 7) / 8;
            fresh = window >> (64 - 8 * nbytes);
            spare = 8 * nbytes - miss;
            old_bits = (have == 0) ? '0 : ({32'b0, hold_word} >> (WORD_BITS - have));
            new_bits = (fresh >> spare) & ((64'd1 << miss) - 64'd1);
            res.value = ((old_bits << miss) | new_bits) & ((64'd1 << want) - 64'd1);
            refill = (fresh & ((64'd1 << spare) - 64'd1)) << (WORD_BITS - spare);
            hold_word = refill[WORD_BITS-1:0];
            hold_count = 6'(spare);
            res.bytes_used = USED_W'(nbytes);
         end
      end
      return res;
   endfunction

   // Compare each result transfer with the oldest prediction, then record new requests.
   always @(posedge clock) begin
      read_result_type exp_read;
      if (reset) begin
         expected_reads.delete();
         hold_word = '0;
         hold_count = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reads.size() == 0) begin
               $error("result transfer with no request waiting: value %0h bytes_used %0d",
                      rsp_value, rsp_bytes_used);
               mismatch_count++;
            end else begin
               exp_read = expected_reads.pop_front();
               if (rsp_value !== exp_read.value) begin
                  $error("value: expected %0h, actual %0h", exp_read.value, rsp_value);
                  mismatch_count++;
               end
               if (rsp_bytes_used !== exp_read.bytes_used) begin
                  $error("bytes_used: expected %0d, actual %0d",
                         exp_read.bytes_used, rsp_bytes_used);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_reads.push_back(predict_read(action_type'(req_action), req_bit_count,
                                                  req_byte_count, req_window));
         end
      end
      failures <= mismatch_count;
      outstanding <= expected_reads.size();
   end

endmodule

### test/msb_first_bit_reader_test.sv
// Testbench top for the MSB-first bit reader: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module msb_first_bit_reader_test;
   import mbr_pkg::*;

   localparam int RANDOM_READS    = 1700;
   localparam int HOLDOFF_AFTER   = 600;
   localparam int HOLDOFF_CYCLES  = 300;
   localparam int PAUSE_AFTER     = 1000;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 10;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_action     = 1'b0;
   logic [BITCNT_W-1:0]   req_bit_count  = '0;
   logic [BYTECNT_W-1:0]  req_byte_count = '0;
   logic [WIN_W-1:0]      req_window     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic [USED_W-1:0]     rsp_bytes_used;

   int failures;
   int outstanding;
   int reads_sent = 0;
   int burst_left = 0;

   msb_first_bit_reader dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_bit_count  (req_bit_count),
      .req_byte_count (req_byte_count),
      .req_window     (req_window),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_bytes_used (rsp_bytes_used)
   );

   msb_first_bit_reader_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_bit_count  (req_bit_count),
      .req_byte_count (req_byte_count),
      .req_window     (req_window),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_bytes_used (rsp_bytes_used),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one request in the current burst and waits for its transfer.
   task automatic issue_read(input action_type act, input logic [BITCNT_W-1:0] bit_cnt,
                             input logic [BYTECNT_W-1:0] byte_cnt,
                             input logic [WIN_W-1:0] window);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_bit_count <= bit_cnt;
      req_byte_count <= byte_cnt;
      req_window <= window;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      reads_sent++;
   endtask

   // Stops offering and waits until every predicted result has come back.
   task automatic drain_reads();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Main stimulus: directed requests, then random ones, then the verdict.
   initial begin
      int          roll;
      action_type  act;
      logic [5:0]  bit_cnt;
      logic [3:0]  byte_cnt;
      logic [63:0] window;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part: zero-bit reads, refills, clamped counts and aligned reads.
      issue_read(ACT_BIT_FIELD, 6'd0, 4'd0, '1);
      issue_read(ACT_BIT_FIELD, 6'd32, 4'd0, '1);
      issue_read(ACT_BIT_FIELD, 6'd1, 4'd0, 64'h8000_0000_0000_0000);
      issue_read(ACT_BIT_FIELD, 6'd3, 4'd0, '0);
      issue_read(ACT_BIT_FIELD, 6'd4, 4'd0, '0);
      issue_read(ACT_BIT_FIELD, 6'd5, 4'd15, 64'hA5A5_A5A5_A5A5_A5A5);
      issue_read(ACT_BIT_FIELD, 6'd0, 4'd0, 64'h5A5A_5A5A_5A5A_5A5A);
      issue_read(ACT_BIT_FIELD, 6'd32, 4'd0, 64'h0123_4567_89AB_CDEF);
      issue_read(ACT_BIT_FIELD, 6'd63, 4'd0, 64'hFEDC_BA98_7654_3210);
      issue_read(ACT_BIT_FIELD, 6'd33, 4'd0, 64'h5A5A_5A5A_5A5A_5A5A);
      issue_read(ACT_BYTE_ALIGNED, 6'd0, 4'd0, '1);
      issue_read(ACT_BIT_FIELD, 6'd7, 4'd0, 64'hC3C3_C3C3_C3C3_C3C3);
      issue_read(ACT_BYTE_ALIGNED, 6'd0, 4'd1, 64'hDEAD_BEEF_0BAD_F00D);
      issue_read(ACT_BIT_FIELD, 6'd12, 4'd0, 64'h9876_5432_10FE_DCBA);
      issue_read(ACT_BYTE_ALIGNED, 6'd63, 4'd8, '1);
      issue_read(ACT_BYTE_ALIGNED, 6'd0, 4'd15, 64'h1122_3344_5566_7788);
      issue_read(ACT_BYTE_ALIGNED, 6'd0, 4'd9, 64'h8877_6655_4433_2211);
      issue_read(ACT_BIT_FIELD, 6'd20, 4'd0, '0);
      issue_read(ACT_BIT_FIELD, 6'd17, 4'd0, '1);
      issue_read(ACT_BIT_FIELD, 6'd32, 4'd8, '0);
      issue_read(ACT_BIT_FIELD, 6'd31, 4'd0, 64'h3C3C_F0F0_0F0F_C3C3);
      issue_read(ACT_BYTE_ALIGNED, 6'd32, 4'd4, '0);
      drain_reads();

      // Random part: mostly legal counts, with clamped and zero counts mixed in.
      for (int i = 0; i < RANDOM_READS; i++) begin
         act = ($urandom_range(0, 4) == 0) ? ACT_BYTE_ALIGNED : ACT_BIT_FIELD;
         roll = $urandom_range(0, 99);
         if (roll < 5)
            bit_cnt = 6'd0;
         else if (roll < 75)
            bit_cnt = 6'($urandom_range(1, 32));
         else if (roll < 90)
            bit_cnt = 6'($urandom_range(1, 8));
         else
            bit_cnt = 6'($urandom_range(33, 63));
         byte_cnt = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8))
                                                 : 4'($urandom_range(0, 15));
         roll = $urandom_range(0, 19);
         if (roll == 0)
            window = '0;
         else if (roll == 1)
            window = '1;
         else
            window = {$urandom(), $urandom()};
         issue_read(act, bit_cnt, byte_cnt, window);
         if (reads_sent == PAUSE_AFTER)
            drain_reads();
      end
      drain_reads();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Result side: stall in segments of varying style, with one long hold-off.
   initial begin
      int              seg_len;
      int              phase;
      stall_style_type style;
      bit              held_off;

      held_off = 1'b0;
      phase = 0;
      forever begin
         seg_len = $urandom_range(10, 150);
         style = stall_style_type'($urandom_range(0, 3));
         repeat (seg_len) begin
            @(negedge clock);
            phase++;
            case (style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 1) == 1);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 8);
               STALL_PERIODIC: rsp_stall <= ((phase % 5) < 2);
               default:        rsp_stall <= 1'b0;
            endcase
         end
         // Hold off long enough that the block fills and stalls its requests.
         if (!held_off && reads_sent >= HOLDOFF_AFTER) begin
            held_off = 1'b1;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES - 1) @(negedge clock);
         end
      end
   end

   // Watchdog: end the run when no transfer happens on either side for too long.
   initial begin
      int idle_cycles;

      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/mbr_pkg.sv
rtl/msb_first_bit_reader.sv
rtl/mbr_checker.sv
test/msb_first_bit_reader_checker.sv
test/msb_first_bit_reader_test.sv
